// File: hw/rtl/mss_pkg.sv
// Shared constants, types and register codes for the masked signature scan.
package mss_pkg;

  localparam int MAX_PATTERN_BYTES = 8;
  localparam int OFFSET_BITS       = 16;
  localparam int POS_BITS          = OFFSET_BITS + 1;
  localparam int PAT_IDX_BITS      = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int LEN_BITS          = 4;
  localparam int COUNT_BITS        = 8;
  localparam int CFG_IDX_BITS      = 3;
  localparam int CFG_DATA_BITS     = 64;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'hff;
  localparam logic [POS_BITS-1:0]   POS_MAX   = {POS_BITS{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_OFFSET_MIN     = 3'd0,
    REG_OFFSET_MAX     = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_VERIFY_BYTES   = 3'd3,
    REG_VERIFY_MASK    = 3'd4
  } reg_index_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_UNIQUE = 2'd0,
    STATUS_NONE   = 2'd1,
    STATUS_MULTI  = 2'd2
  } status_t;

  // One byte in the test stage, handed from the window front end to the tally
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic                   check;
    logic [OFFSET_BITS-1:0] start;
  } test_t;

endpackage

// File: hw/rtl/mss_cell.sv
// One window cell: holds a byte, passes it on, and compares it to its signature byte.
module mss_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] byte_in,
  output logic [7:0] byte_out,
  input  logic [7:0] pat_byte,
  input  logic [7:0] pat_mask,
  input  logic       active,
  output logic       hit
);

  logic [7:0] window_byte;

  // shift register stage
  always_ff @(posedge clk) begin
    if (shift) begin
      window_byte <= byte_in;
    end
  end

  assign byte_out = window_byte;

  // masked compare; unused cells always agree
  assign hit = !active || ((window_byte & pat_mask) == (pat_byte & pat_mask));

endmodule

// File: hw/rtl/mss_tally.sv
// Match tally: counts hits, keeps the first offset and holds the result item.
module mss_tally (
  input  logic                            clk,
  input  logic                            rst,
  input  mss_pkg::test_t                  test,
  input  logic                            match,
  output logic                            hold,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      status,
  output logic [mss_pkg::OFFSET_BITS-1:0] match_offset,
  output logic [mss_pkg::COUNT_BITS-1:0]  match_count
);

  logic [mss_pkg::COUNT_BITS-1:0]  hit_count;
  logic [mss_pkg::COUNT_BITS-1:0]  hit_count_next;
  logic [mss_pkg::OFFSET_BITS-1:0] first_hit;
  logic [mss_pkg::OFFSET_BITS-1:0] first_hit_next;
  logic                            hit;
  logic                            advance;
  logic                            load_out;
  mss_pkg::status_t                status_next;

  // the final byte waits while the previous result is still stalled
  assign hold     = test.valid && test.last && out_valid && out_stall;
  assign advance  = test.valid && !hold;
  assign load_out = advance && test.last;

  // running count and first offset including this byte
  always_comb begin
    hit            = test.check && match;
    hit_count_next = hit_count;
    first_hit_next = first_hit;
    if (hit) begin
      if (hit_count == '0) begin
        first_hit_next = test.start;
      end
      if (hit_count != mss_pkg::COUNT_MAX) begin
        hit_count_next = hit_count + 1'b1;
      end
    end
  end

  always_comb begin
    if (hit_count_next == '0) begin
      status_next = mss_pkg::STATUS_NONE;
    end else if (hit_count_next == {{(mss_pkg::COUNT_BITS-1){1'b0}}, 1'b1}) begin
      status_next = mss_pkg::STATUS_UNIQUE;
    end else begin
      status_next = mss_pkg::STATUS_MULTI;
    end
  end

  // tally state, cleared after each scan
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count <= '0;
      first_hit <= '0;
    end else if (advance) begin
      if (test.last) begin
        hit_count <= '0;
        first_hit <= '0;
      end else begin
        hit_count <= hit_count_next;
        first_hit <= first_hit_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status       <= status_next;
      match_offset <= first_hit_next;
      match_count  <= hit_count_next;
    end
  end

  a_hold_needs_result: assert property (@(posedge clk) disable iff (rst)
    hold |-> out_valid && test.last)
    else $error("scan held without a pending result");

  a_none_is_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mss_pkg::STATUS_NONE |-> match_count == '0 && match_offset == '0)
    else $error("no-match result carries a count or offset");

  a_unique_is_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mss_pkg::STATUS_UNIQUE |-> match_count == 8'd1)
    else $error("unique result with count other than one");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    hold |=> out_valid)
    else $error("pending result lost while scan held");

endmodule

// File: hw/rtl/masked_signature_scan_top.sv
// Masked signature scan: chain of window cells, test stage and match tally.
// Throughput: one byte per cycle; the input stalls only while a final byte waits
//   behind a result that is itself stalled.
// Timing: a final byte's window shift and range check are registered in the test stage;
//   the masked compare and tally then load the output register, unless a stalled result holds it.
// Reset clears the scan position, tally and config registers to their defaults;
//   window bytes are not cleared, since bytes before the scan start are never compared.
module masked_signature_scan_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [mss_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [mss_pkg::CFG_DATA_BITS-1:0] wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [mss_pkg::OFFSET_BITS-1:0]   match_offset,
  output logic [mss_pkg::COUNT_BITS-1:0]    match_count
);

  localparam int NB = mss_pkg::MAX_PATTERN_BYTES;

  logic [mss_pkg::OFFSET_BITS-1:0] offset_min;
  logic [mss_pkg::OFFSET_BITS-1:0] offset_max;
  logic [mss_pkg::LEN_BITS-1:0]    pattern_length;
  logic [8*NB-1:0]                 verify_bytes;
  logic [8*NB-1:0]                 verify_mask;

  logic [mss_pkg::POS_BITS-1:0]    byte_position;
  logic [mss_pkg::LEN_BITS-1:0]    used_len;
  logic [mss_pkg::POS_BITS:0]      pos_plus;
  logic [mss_pkg::POS_BITS:0]      start_full;
  logic                            eligible;
  logic                            in_range;
  logic                            accept;
  logic                            hold;
  logic                            match;
  mss_pkg::test_t                  test;

  logic [7:0]                      cell_byte [NB];
  logic [NB-1:0]                   cell_hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_min     <= '0;
      offset_max     <= '0;
      pattern_length <= {{(mss_pkg::LEN_BITS-1){1'b0}}, 1'b1};
      verify_bytes   <= '0;
      verify_mask    <= '1;
    end else if (wr_en) begin
      case (mss_pkg::reg_index_t'(wr_index))
        mss_pkg::REG_OFFSET_MIN:     offset_min     <= wr_data[mss_pkg::OFFSET_BITS-1:0];
        mss_pkg::REG_OFFSET_MAX:     offset_max     <= wr_data[mss_pkg::OFFSET_BITS-1:0];
        mss_pkg::REG_PATTERN_LENGTH: pattern_length <= wr_data[mss_pkg::LEN_BITS-1:0];
        mss_pkg::REG_VERIFY_BYTES:   verify_bytes   <= wr_data[8*NB-1:0];
        mss_pkg::REG_VERIFY_MASK:    verify_mask    <= wr_data[8*NB-1:0];
        default: ;
      endcase
    end
  end

  // signature length in use: zero reads as one, clamped to the window
  always_comb begin
    if (pattern_length == '0) begin
      used_len = {{(mss_pkg::LEN_BITS-1){1'b0}}, 1'b1};
    end else if (pattern_length > mss_pkg::LEN_BITS'(NB)) begin
      used_len = mss_pkg::LEN_BITS'(NB);
    end else begin
      used_len = pattern_length;
    end
  end

  assign accept   = in_valid && !hold;
  assign in_stall = hold;

  // start offset of the test completed by this byte, and its window check
  assign pos_plus   = {1'b0, byte_position} + 1'b1;
  assign eligible   = pos_plus >= (mss_pkg::POS_BITS+1)'(used_len);
  assign start_full = pos_plus - (mss_pkg::POS_BITS+1)'(used_len);
  assign in_range   = (start_full >= (mss_pkg::POS_BITS+1)'(offset_min))
                   && (start_full <= (mss_pkg::POS_BITS+1)'(offset_max));

  // byte position, saturating, cleared at the end of a scan
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept) begin
      if (last) begin
        byte_position <= '0;
      end else if (byte_position != mss_pkg::POS_MAX) begin
        byte_position <= byte_position + 1'b1;
      end
    end
  end

  // test stage register, lines up with the shifted window
  always_ff @(posedge clk) begin
    if (rst) begin
      test.valid <= 1'b0;
    end else if (!hold) begin
      test.valid <= in_valid;
    end
    if (accept) begin
      test.last  <= last;
      test.check <= eligible && in_range;
      test.start <= start_full[mss_pkg::OFFSET_BITS-1:0];
    end
  end

  // window cells: cell 0 holds the newest byte, compared with signature byte len-1-k
  for (genvar k = 0; k < NB; k++) begin : g_cell
    logic [mss_pkg::LEN_BITS-1:0]     idx_full;
    logic [mss_pkg::PAT_IDX_BITS-1:0] idx;
    logic [7:0]                       chain_in;

    assign idx_full = used_len - mss_pkg::LEN_BITS'(k) - 1'b1;
    assign idx      = idx_full[mss_pkg::PAT_IDX_BITS-1:0];

    if (k == 0) begin : g_head
      assign chain_in = data_byte;
    end else begin : g_link
      assign chain_in = cell_byte[k-1];
    end

    mss_cell u_cell (
      .clk      (clk),
      .shift    (accept),
      .byte_in  (chain_in),
      .byte_out (cell_byte[k]),
      .pat_byte (verify_bytes[8*idx +: 8]),
      .pat_mask (verify_mask[8*idx +: 8]),
      .active   (mss_pkg::LEN_BITS'(k) < used_len),
      .hit      (cell_hit[k])
    );
  end

  assign match = &cell_hit;

  mss_tally u_tally (
    .clk          (clk),
    .rst          (rst),
    .test         (test),
    .match        (match),
    .hold         (hold),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .match_offset (match_offset),
    .match_count  (match_count)
  );

endmodule

// File: sim/tb.sv
// Testbench for masked_signature_scan_top: random and directed scans checked against a predictor.
module tb;
  import mss_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 80;
  localparam int SEGMENTS     = 12;
  localparam int SEG_ITEMS    = 40;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     wr_en     = 1'b0;
  logic [CFG_IDX_BITS-1:0]  wr_index  = '0;
  logic [CFG_DATA_BITS-1:0] wr_data   = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [7:0]               data_byte = '0;
  logic                     last      = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic [OFFSET_BITS-1:0]   match_offset;
  logic [COUNT_BITS-1:0]    match_count;

  int send_idle_pct = 12;
  int recv_idle_pct = 61;
  int hold_requests = 0;

  masked_signature_scan_top dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .match_offset(match_offset), .match_count(match_count)
  );

  typedef struct {
    status_t                code;
    logic [OFFSET_BITS-1:0] offset;
    logic [COUNT_BITS-1:0]  count;
  } scan_report_t;

  // Tracks the scan state and register copies, and queues the report each scan should give
  class signature_tally;
    logic [OFFSET_BITS-1:0] win_lo, win_hi;
    logic [LEN_BITS-1:0]    len_reg;
    logic [63:0]            sig, sig_mask;
    logic [7:0]             recent [MAX_PATTERN_BYTES];
    logic [POS_BITS-1:0]    pos;
    logic [COUNT_BITS-1:0]  hits;
    logic [OFFSET_BITS-1:0] first_hit;
    scan_report_t           expected_reports [$];
    int                     errors;

    function new();
      win_lo   = '0;
      win_hi   = '0;
      len_reg  = 4'd1;
      sig      = '0;
      sig_mask = '1;
      errors   = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (recent[i]) recent[i] = '0;
      pos       = '0;
      hits      = '0;
      first_hit = '0;
    endfunction

    // Zero length acts as one, anything above the window depth is clipped
    function int used_len();
      if (len_reg == 0) return 1;
      if (len_reg > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
      return int'(len_reg);
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] val);
      case (idx)
        REG_OFFSET_MIN:     win_lo   = val[OFFSET_BITS-1:0];
        REG_OFFSET_MAX:     win_hi   = val[OFFSET_BITS-1:0];
        REG_PATTERN_LENGTH: len_reg  = val[LEN_BITS-1:0];
        REG_VERIFY_BYTES:   sig      = val;
        REG_VERIFY_MASK:    sig_mask = val;
        default: ;
      endcase
    endfunction

    // Signature byte 0 lines up with the oldest of the newest n bytes
    function bit window_hit(int n);
      logic [7:0] v, m, b;
      for (int i = 0; i < n; i++) begin
        v = sig[8*i +: 8];
        m = sig_mask[8*i +: 8];
        b = recent[n-1-i];
        if ((b & m) != (v & m)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_byte(logic [7:0] b, logic l);
      int n, start;
      scan_report_t rep;
      n = used_len();
      for (int i = MAX_PATTERN_BYTES-1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      // the start offset whose last signature byte is this one
      start = int'(pos) + 1 - n;
      if (start >= 0 && start >= int'(win_lo) && start <= int'(win_hi) && window_hit(n)) begin
        if (hits == 0) first_hit = start[OFFSET_BITS-1:0];
        if (hits != COUNT_MAX) hits++;
      end
      if (pos != POS_MAX) pos++;
      if (l) begin
        rep.code   = (hits == 1) ? STATUS_UNIQUE : ((hits == 0) ? STATUS_NONE : STATUS_MULTI);
        rep.offset = (hits == 0) ? '0 : first_hit;
        rep.count  = hits;
        expected_reports.insert(expected_reports.size(), rep);
        clear_scan();
      end
    endfunction

    function void check_report(logic [1:0] code, logic [OFFSET_BITS-1:0] offset,
                               logic [COUNT_BITS-1:0] count);
      scan_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result: status %0d offset %0d count %0d",
                 $time, code, offset, count);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (code !== want.code) begin
        $display("%0t: status expected %0d, actual %0d", $time, want.code, code);
        errors++;
      end
      if (offset !== want.offset) begin
        $display("%0t: match_offset expected %0d, actual %0d", $time, want.offset, offset);
        errors++;
      end
      if (count !== want.count) begin
        $display("%0t: match_count expected %0d, actual %0d", $time, want.count, count);
        errors++;
      end
    endfunction
  endclass

  signature_tally tally;

  initial forever #CLK_HALF clk = ~clk;

  // Accepted bytes and results
  always @(posedge clk) begin
    if (rst === 1'b0 && in_valid === 1'b1 && in_stall === 1'b0)
      tally.take_byte(data_byte, last);
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
      tally.check_report(status, match_offset, match_count);
  end

  // Result side: random stall, plus a long hold-off on request so the block backs up
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = holds_done + 1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last      <= l;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Random bytes with the signature planted at random places; bits outside the mask stay random
  task automatic send_scan(input int nbytes, input int hit_pct, input bit closed);
    int plen, j;
    logic [7:0] b, m;
    plen = tally.used_len();
    j = -1;
    for (int i = 0; i < nbytes; i++) begin
      if (j < 0 && $urandom_range(99) < hit_pct) j = 0;
      b = 8'($urandom);
      if (j >= 0) begin
        m = tally.sig_mask[8*j +: 8];
        b = (tally.sig[8*j +: 8] & m) | (b & ~m);
        j = (j == plen - 1) ? -1 : j + 1;
      end
      send_byte(b, closed && (i == nbytes - 1));
    end
  endtask

  // Stop offering, let all results drain and the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tally.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    tally.write_reg(idx, val);
  endtask

  // Full register set; unused upper bits carry junk, and one spare index gets a write too
  task automatic set_config(input logic [15:0] lo, input logic [15:0] hi, input logic [3:0] len,
                            input logic [63:0] sig, input logic [63:0] msk);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    put_reg(REG_OFFSET_MIN, {junk[63:16], lo});
    junk = {$urandom, $urandom};
    put_reg(REG_OFFSET_MAX, {junk[63:16], hi});
    junk = {$urandom, $urandom};
    put_reg(REG_PATTERN_LENGTH, {junk[63:4], len});
    put_reg(REG_VERIFY_BYTES, sig);
    put_reg(REG_VERIFY_MASK, msk);
    put_reg(REG_SPARE_LO + CFG_IDX_BITS'($urandom_range(2)), {$urandom, $urandom});
    wr_en <= 1'b0;
  endtask

  task automatic random_config(input bit wide);
    logic [15:0] lo, hi;
    logic [3:0]  len;
    logic [63:0] sig, msk;
    int pick;
    pick = $urandom_range(99);
    lo   = (pick < 25) ? 16'd0 : ((pick < 35) ? 16'hffff : 16'($urandom_range(12)));
    pick = $urandom_range(99);
    hi   = (pick < 15) ? 16'hffff : ((pick < 25) ? 16'd0 : 16'($urandom_range(80)));
    len  = 4'($urandom_range(15));
    sig  = {$urandom, $urandom};
    for (int k = 0; k < 8; k++) begin
      pick = $urandom_range(9);
      msk[8*k +: 8] = (pick < 5) ? 8'hff : ((pick < 7) ? 8'h00 : 8'($urandom));
    end
    // wide open: every offset from lo upward matches, so a long scan drives the count toward saturation
    if (wide) begin
      lo  = 16'($urandom_range(5));
      hi  = 16'hffff;
      msk = '0;
    end
    set_config(lo, hi, len, sig, msk);
  endtask

  initial begin
    int seg_items, nbytes, pick;
    bit closed, wide;
    tally = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: one-byte signature 0x00 at offset 0 only
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);

    // length zero acts as one; several hits
    wait_idle();
    set_config(16'd0, 16'hffff, 4'd0, {$urandom, 32'h000000a5}, '1);
    send_byte(8'ha5, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'ha5, 1'b1);

    // length above the window depth is clipped
    wait_idle();
    set_config(16'd0, 16'hffff, 4'd15, {$urandom, $urandom}, '1);
    send_scan(9, 100, 1'b1);

    // empty window
    wait_idle();
    set_config(16'd10, 16'd5, 4'd1, '0, '0);
    send_scan(3, 0, 1'b1);

    // registers changed in the middle of a scan
    wait_idle();
    set_config(16'd0, 16'hffff, 4'd2, {$urandom, $urandom}, '1);
    send_scan(3, 100, 1'b0);
    wait_idle();
    set_config(16'd0, 16'hffff, 4'd1, {$urandom, $urandom}, '0);
    send_scan(3, 0, 1'b1);

    // results pile up behind a long hold-off until the input stalls
    wait_idle();
    set_config(16'd0, 16'hffff, 4'd1, '0, '0);
    hold_requests <= hold_requests + 1;
    repeat (8) send_scan(2, 0, 1'b1);

    // random phases
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == SEGMENTS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 12;
      end
      if (seg == 2 * SEGMENTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wide = (seg % 4 == 3);
      wait_idle();
      random_config(wide);
      seg_items = 0;
      while (seg_items < SEG_ITEMS) begin
        pick = $urandom_range(99);
        if (wide && seg_items == 0)
          nbytes = $urandom_range(256, 264);
        else if (pick < 70)
          nbytes = $urandom_range(1, 12);
        else
          nbytes = $urandom_range(13, 60);
        // sometimes leave the scan open across the next register change
        closed = (seg_items + nbytes < SEG_ITEMS) || ($urandom_range(4) != 0);
        send_scan(nbytes, 30, closed);
        seg_items += nbytes;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (tally.expected_reports.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tally.expected_reports.size());
      tally.errors++;
    end
    if (tally.errors == 0) begin
      $display("[masked_signature_scan_top] OK");
    end else begin
      $display("[masked_signature_scan_top] ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("[masked_signature_scan_top] ERROR");
    $finish;
  end

endmodule
